>>> src/fixed_point_alu_macros.svh
// ----------------------------------------------------------------------------
// fixed_point_alu_macros
// Assertion macros shared by the ALU top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH
// Property holds at every rising clock edge outside reset.
`define FPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property is checked during reset as well.
`define FPA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and operation codes of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int WORD_W = 32;
    localparam int MODE_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_MUL     = 4'd2,
        MODE_DIV     = 4'd3,
        MODE_GT      = 4'd4,
        MODE_LT      = 4'd5,
        MODE_GE      = 4'd6,
        MODE_LE      = 4'd7,
        MODE_EQ      = 4'd8,
        MODE_NE      = 4'd9,
        MODE_MIN     = 4'd10,
        MODE_MAX     = 4'd11,
        MODE_INC     = 4'd12,
        MODE_DEC     = 4'd13,
        MODE_TOINT   = 4'd14,
        MODE_FROMINT = 4'd15
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                     compare_true;
        logic                     divide_by_zero;
    } out_beat_t;

endpackage

>>> src/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, 64-bit magnitude.
// ----------------------------------------------------------------------------
module fpa_div
    import fpa_pkg::*;
#(
    parameter int QW = 64
)
(
    input  logic              clk,
    input  logic              advance,
    input  logic [QW-1:0]     dividend,
    input  logic [WORD_W-1:0] divisor,
    input  logic              negate,
    output logic [QW-1:0]     quotient
);

    localparam int DW = WORD_W + 1;

    logic [QW-1:0] num_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic          neg_reg [QW+1];

    always_comb
    begin
        num_reg[0] = dividend;
        quo_reg[0] = '0;
        rem_reg[0] = '0;
        den_reg[0] = {1'b0, divisor};
        neg_reg[0] = negate;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0]   trial;
        logic [DW-1:0] shifted;
        always_comb
        begin
            shifted = {rem_reg[s][DW-2:0], num_reg[s][QW-1]};
            trial   = {1'b0, shifted} - {1'b0, den_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                num_reg[s+1] <= {num_reg[s][QW-2:0], 1'b0};
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                rem_reg[s+1] <= trial[DW] ? shifted : trial[DW-1:0];
                quo_reg[s+1] <= {quo_reg[s][QW-2:0], ~trial[DW]};
            end
        end
    end

    assign quotient = neg_reg[QW] ? (~quo_reg[QW] + QW'(1)) : quo_reg[QW];

endmodule

>>> src/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// Signed 32x32 multiply from two 16-bit partial products, then their sum.
// ----------------------------------------------------------------------------
module fpa_mul
    import fpa_pkg::*;
(
    input  logic                      clk,
    input  logic                      advance,
    input  logic signed [WORD_W-1:0]  a,
    input  logic signed [WORD_W-1:0]  b,
    output logic signed [2*WORD_W-1:0] product
);

    logic signed [WORD_W+16:0] lo_reg, hi_reg;
    logic signed [2*WORD_W-1:0] prod_reg;

    // Split b into an unsigned low half and a signed high half.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_reg   <= a * $signed({1'b0, b[15:0]});
            hi_reg   <= a * $signed(b[31:16]);
            prod_reg <= (2*WORD_W)'(lo_reg) + ((2*WORD_W)'(hi_reg) <<< 16);
        end
    end

    assign product = prod_reg;

endmodule

>>> src/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries mode, operand_a and operand_b; the
// output channel out_valid/out_stall carries result, compare_true and
// divide_by_zero. One result beat follows every input beat, in order.
// Every operation passes through the same 65-stage pipeline, which takes
// one beat per cycle while no output stall holds it. The depth is set by the
// operand stage plus the divider, which resolves one quotient bit per stage
// over a 64-bit dividend.
// The multiplier follows the operand stage; simple operations ride along.
// While out_stall holds with a valid beat at the end, the whole pipeline
// freezes and in_stall rises; no beat is dropped or repeated. A bubble at
// the end never stalls the pipe.
// Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_macros.svh"
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    localparam int QW    = 2 * WORD_W;
    localparam int DEPTH = QW + 1;

    logic advance;
    logic [DEPTH-1:0] vld_reg, vld_next;

    assign advance  = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !advance;

    // Stage 0: register the operands and precompute the simple results.
    out_beat_t s0_reg;
    logic      s0_mul_reg, s0_div_reg;
    logic signed [WORD_W-1:0] a0_reg, b0_reg;
    logic [QW-1:0]     dvd0_reg;
    logic [WORD_W-1:0] dvs0_reg;
    logic              neg0_reg;

    logic signed [WORD_W-1:0] a, b;
    logic signed [QW-1:0]     dividend;
    logic [QW-1:0]            dvd_mag;
    out_beat_t                simple;

    always_comb
    begin
        a = in_data.operand_a;
        b = in_data.operand_b;
        dividend = QW'(a) <<< FRAC_BITS;
        dvd_mag  = dividend[QW-1] ? (~dividend + QW'(1)) : dividend;
        simple = '0;
        case (mode_t'(in_data.mode))
            MODE_ADD:     simple.result = a + b;
            MODE_SUB:     simple.result = a - b;
            MODE_GT:      simple.compare_true = a > b;
            MODE_LT:      simple.compare_true = a < b;
            MODE_GE:      simple.compare_true = a >= b;
            MODE_LE:      simple.compare_true = a <= b;
            MODE_EQ:      simple.compare_true = a == b;
            MODE_NE:      simple.compare_true = a != b;
            MODE_MIN:     simple.result = (a < b) ? a : b;
            MODE_MAX:     simple.result = (a > b) ? a : b;
            MODE_INC:     simple.result = a + 32'sd1;
            MODE_DEC:     simple.result = a - 32'sd1;
            MODE_TOINT:   simple.result = a >>> FRAC_BITS;
            MODE_FROMINT: simple.result = a <<< FRAC_BITS;
            MODE_DIV:     simple.divide_by_zero = (b == 0);
            default:      simple = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg     <= simple;
            s0_mul_reg <= (in_data.mode == MODE_MUL);
            s0_div_reg <= (in_data.mode == MODE_DIV) && (b != 0);
            a0_reg     <= a;
            b0_reg     <= b;
            dvd0_reg   <= dvd_mag;
            dvs0_reg   <= b[WORD_W-1] ? (~b + 32'd1) : b;
            neg0_reg   <= dividend[QW-1] ^ b[WORD_W-1];
        end
    end

    logic signed [QW-1:0] product;
    logic [QW-1:0]        quotient;

    fpa_mul u_mul (
        .clk     (clk),
        .advance (advance),
        .a       (a0_reg),
        .b       (b0_reg),
        .product (product)
    );

    fpa_div #(.QW(QW)) u_div (
        .clk      (clk),
        .advance  (advance),
        .dividend (dvd0_reg),
        .divisor  (dvs0_reg),
        .negate   (neg0_reg),
        .quotient (quotient)
    );

    // Side line carrying the simple result and select bits to the end.
    typedef struct packed {
        out_beat_t beat;
        logic      mul;
        logic      div;
    } side_t;

    side_t side_reg [DEPTH-1];
    logic signed [WORD_W-1:0] mulres_reg;
    logic signed [QW-1:0]     prod_sh;

    assign prod_sh = product >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= '{beat: s0_reg, mul: s0_mul_reg, div: s0_div_reg};
            for (int i = 1; i < DEPTH - 1; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Hold the product until the quotient arrives.
    logic signed [WORD_W-1:0] mul_line_reg [QW-3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mul_line_reg[0] <= prod_sh[WORD_W-1:0];
            for (int i = 1; i < QW - 3; i++)
                mul_line_reg[i] <= mul_line_reg[i-1];
            mulres_reg <= mul_line_reg[QW-4];
        end
    end

    out_beat_t final_beat;
    always_comb
    begin
        final_beat = side_reg[DEPTH-2].beat;
        if (side_reg[DEPTH-2].mul)
            final_beat.result = mulres_reg;
        else if (side_reg[DEPTH-2].div)
            final_beat.result = quotient[WORD_W-1:0];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (advance)
            vld_next = {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = final_beat;

    `FPA_ASSERT(a_hold_on_stall, (out_valid && out_stall) |=> out_valid, "beat lost")
    `FPA_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "stall mismatch")
    `FPA_ASSERT(a_flags_exclusive, out_valid |-> !(out_data.compare_true && out_data.divide_by_zero), "flags clash")
    `FPA_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "valid in reset")

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the fixed-point ALU: directed corner beats,
// then random beats, each checked in order against a predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
    import fpa_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = 65;
    localparam int N_RANDOM = 1000;
    localparam longint CYCLE_LIMIT = 400000;

    class alu_scoreboard;
        out_beat_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function out_beat_t compute(in_beat_t x);
            out_beat_t         r;
            logic signed [63:0] a;
            logic signed [63:0] b;
            logic signed [63:0] p;
            begin
                r = '0;
                a = {{32{x.operand_a[31]}}, x.operand_a};
                b = {{32{x.operand_b[31]}}, x.operand_b};
                case (mode_t'(x.mode))
                    MODE_ADD: r.result = x.operand_a + x.operand_b;
                    MODE_SUB: r.result = x.operand_a - x.operand_b;
                    MODE_MUL:
                    begin
                        p = a * b;
                        p = p >>> FRAC;
                        r.result = p[31:0];
                    end
                    MODE_DIV:
                    begin
                        if (b == 0)
                            r.divide_by_zero = 1'b1;
                        else
                        begin
                            p = (a <<< FRAC) / b;
                            r.result = p[31:0];
                        end
                    end
                    MODE_GT: r.compare_true = a > b;
                    MODE_LT: r.compare_true = a < b;
                    MODE_GE: r.compare_true = a >= b;
                    MODE_LE: r.compare_true = a <= b;
                    MODE_EQ: r.compare_true = a == b;
                    MODE_NE: r.compare_true = a != b;
                    MODE_MIN: r.result = (a < b) ? x.operand_a : x.operand_b;
                    MODE_MAX: r.result = (a > b) ? x.operand_a : x.operand_b;
                    MODE_INC: r.result = x.operand_a + 32'sd1;
                    MODE_DEC: r.result = x.operand_a - 32'sd1;
                    MODE_TOINT: r.result = x.operand_a >>> FRAC;
                    default:
                    begin
                        p = a <<< FRAC;
                        r.result = p[31:0];
                    end
                endcase
                return r;
            end
        endfunction

        function void note_input(in_beat_t x);
            pending.push_back(compute(x));
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            begin
                if (pending.size() == 0)
                begin
                    $error("unexpected result beat %h", got);
                    errors++;
                    return;
                end
                want = pending.pop_front();
                if (got.result !== want.result)
                begin
                    $error("result: expected %h actual %h", want.result, got.result);
                    errors++;
                end
                if (got.compare_true !== want.compare_true)
                begin
                    $error("compare_true: expected %b actual %b",
                           want.compare_true, got.compare_true);
                    errors++;
                end
                if (got.divide_by_zero !== want.divide_by_zero)
                begin
                    $error("divide_by_zero: expected %b actual %b",
                           want.divide_by_zero, got.divide_by_zero);
                    errors++;
                end
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b1;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;

    alu_scoreboard sb = new();
    longint        cycles = 0;
    bit            quiet_phase = 1'b0;
    bit            hold_out = 1'b0;

    fixed_point_alu #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fixed_point_alu test failed");
            $finish;
        end
    end

    // Sample beats on the edge; check results and note inputs in order.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        if (rst_n && in_valid && !in_stall)
            sb.note_input(in_data);
    end

    // Receiver: random stalls, none in the quiet phase, a long hold on request.
    always @(posedge clk)
    begin
        if (hold_out)
            out_stall <= 1'b1;
        else if (quiet_phase)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 16);
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return $urandom_range(511) - 256;
            4: return {$urandom_range(1) ? 8'hff : 8'h00, 24'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    // Offer one beat, hold it until accepted.
    task automatic send_beat(mode_t m, logic [31:0] a, logic [31:0] b);
        while (!quiet_phase && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{mode: m, operand_a: a, operand_b: b};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random(int n);
        repeat (n)
            send_beat(mode_t'($urandom_range(15)), pick_word(), pick_word());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed corners: every mode on extremes, divide by zero,
        // quotient overflow, fromint overflow, min and max on equal operands.
        for (int m = 0; m < 16; m++)
            send_beat(mode_t'(m), 32'h8000_0000, 32'h7fff_ffff);
        send_beat(MODE_DIV, 32'h0000_0100, 32'h0000_0000);
        send_beat(MODE_DIV, 32'h8000_0000, 32'h0000_0001);
        send_beat(MODE_DIV, 32'hffff_ff00, 32'h0000_0300);
        send_beat(MODE_FROMINT, 32'h7fff_ffff, 32'h0);
        send_beat(MODE_MIN, 32'h1234_5678, 32'h1234_5678);
        send_beat(MODE_MAX, 32'hffff_fff0, 32'hffff_fff0);
        send_beat(MODE_MUL, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(MODE_EQ, 32'h0, 32'h0);
        send_random(N_RANDOM / 4);
        // Hold the receiver off so the pipe fills and stalls its input.
        hold_out = 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(posedge clk);
                hold_out = 1'b0;
            end
            send_random(N_RANDOM / 4);
        join
        quiet_phase = 1'b1;
        send_random(N_RANDOM / 4);
        quiet_phase = 1'b0;
        send_random(N_RANDOM / 4);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("fixed_point_alu test passed");
        else
            $display("fixed_point_alu test failed");
        $finish;
    end
endmodule
